// ===== hdl/assert_macros.svh =====
// ------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands, sampled on clk and held off while rst_n is low
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/jbrs_pkg.sv =====
// ------------------------------------------------------------------------
// jbrs_pkg
// Types and constants shared by the buffered jkiss random source
// ------------------------------------------------------------------------
package jbrs_pkg;

    // request actions
    localparam logic [1:0] ACT_HALF   = 2'd0;
    localparam logic [1:0] ACT_WORD   = 2'd1;
    localparam logic [1:0] ACT_BOUND  = 2'd2;
    localparam logic [1:0] ACT_RESEED = 2'd3;

    // register indexes on the config port
    localparam logic [1:0] REG_SEED_LCG   = 2'd0;
    localparam logic [1:0] REG_SEED_XOR   = 2'd1;
    localparam logic [1:0] REG_SEED_MWC   = 2'd2;
    localparam logic [1:0] REG_SEED_CARRY = 2'd3;

    localparam int CARRY_W = 30;

    localparam logic [31:0] LCG_MUL = 32'd314527869;
    localparam logic [31:0] LCG_ADD = 32'd1234567;
    localparam logic [31:0] MWC_MUL = 32'd4294584393;

    localparam logic [31:0]        DEF_LCG   = 32'd123456789;
    localparam logic [31:0]        DEF_XOR   = 32'd987654321;
    localparam logic [31:0]        DEF_MWC   = 32'd43219876;
    localparam logic [CARRY_W-1:0] DEF_CARRY = 30'd6543217;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] limit;
    } req_t;

    typedef struct packed {
        logic [31:0] value;
        logic        error;
    } rsp_t;

    typedef struct packed {
        logic [31:0]        lcg;
        logic [31:0]        xs;
        logic [31:0]        mwc;
        logic [CARRY_W-1:0] carry;
    } seed_t;

    typedef enum logic [2:0] {
        CLS_HALF,
        CLS_WORD,
        CLS_BOUND,
        CLS_ERROR,
        CLS_RESEED
    } cls_t;

    typedef struct packed {
        cls_t        cls;
        logic [15:0] limit;
        logic [15:0] mask;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REFILL,
        ST_READ,
        ST_DATA,
        ST_FINISH
    } state_t;

endpackage

// ===== hdl/buffered_jkiss_random_source_unit.sv =====
// ------------------------------------------------------------------------
// buffered_jkiss_random_source_unit
// JKISS random source with a halfword buffer, bounded draws and seed registers
// ------------------------------------------------------------------------
// Requests enter a two-deep queue and are served in order, one at a time. A
// 16-bit or 32-bit read passes from the queue head through the READ, DATA and
// FINISH states to the result register when the buffer holds enough halfwords;
// otherwise a refill runs first, in which the generator makes one word per
// cycle into the buffer. A rejected bounded draw goes back through READ and
// DATA (plus a refill if the buffer runs dry); a reseed or an illegal limit
// goes straight to FINISH. Seeds are taken from the registers at the time
// a reseed request reaches the back end.
`include "assert_macros.svh"

module buffered_jkiss_random_source_unit
    import jbrs_pkg::*;
#(
    parameter int BUFFER_WORDS = 512
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  req_t        req,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output rsp_t        rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int HALVES = 2 * BUFFER_WORDS;
    localparam int PW     = $clog2(HALVES + 1);

    seed_t         seed_reg;
    logic          cfg_wr;
    logic          pop;
    logic          head_valid;
    cmd_t          head;
    logic [PW-1:0] pos;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg.lcg   <= DEF_LCG;
            seed_reg.xs    <= DEF_XOR;
            seed_reg.mwc   <= DEF_MWC;
            seed_reg.carry <= DEF_CARRY;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_SEED_LCG:   seed_reg.lcg   <= pwdata;
                REG_SEED_XOR:   seed_reg.xs    <= pwdata;
                REG_SEED_MWC:   seed_reg.mwc   <= pwdata;
                REG_SEED_CARRY: seed_reg.carry <= pwdata[CARRY_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_SEED_LCG:   prdata = seed_reg.lcg;
            REG_SEED_XOR:   prdata = seed_reg.xs;
            REG_SEED_MWC:   prdata = seed_reg.mwc;
            REG_SEED_CARRY: prdata = 32'(seed_reg.carry);
        endcase
    end

    jbrs_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    jbrs_back #(
        .BUFFER_WORDS (BUFFER_WORDS)
    ) u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .seed       (seed_reg),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp),
        .pos        (pos)
    );

    `ASSERT_IMPL(a_err_zero, rsp_valid && rsp.error, rsp.value == 32'd0, "error result with nonzero value")
    `ASSERT_IMPL(a_pop_head, pop, head_valid, "pop from empty request queue")
    `ASSERT_IMPL(a_pos_range, 1'b1, pos <= PW'(HALVES), "read position beyond buffer")
    `ASSERT_NEXT(a_reseed_empty, pop && head.cls == CLS_RESEED, pos == '0, "reseed left buffer nonempty")

endmodule

// ===== hdl/jbrs_gen.sv =====
// ------------------------------------------------------------------------
// jbrs_gen
// JKISS generator state: lcg, xorshift, MWC; one step in each step-high cycle
// ------------------------------------------------------------------------
module jbrs_gen
    import jbrs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  logic        step,
    input  seed_t       seed,
    output logic [31:0] word
);

    logic [31:0] lcg_reg, lcg_next;
    logic [31:0] xs_reg, xs_next;
    logic [31:0] mwc_reg, mwc_next;
    logic [31:0] carry_reg, carry_next;

    logic [31:0] xs_a, xs_b;
    logic [63:0] mwc_prod;

    always_comb
    begin
        lcg_next = lcg_reg * LCG_MUL + LCG_ADD;
        xs_a     = xs_reg ^ (xs_reg << 5);
        xs_b     = xs_a ^ (xs_a >> 7);
        xs_next  = xs_b ^ (xs_b << 22);
        mwc_prod = 64'(mwc_reg) * 64'(MWC_MUL) + 64'(carry_reg);
        mwc_next   = mwc_prod[31:0];
        carry_next = mwc_prod[63:32];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lcg_reg   <= DEF_LCG;
            xs_reg    <= DEF_XOR;
            mwc_reg   <= DEF_MWC;
            carry_reg <= 32'(DEF_CARRY);
        end
        else if (load)
        begin
            lcg_reg   <= seed.lcg;
            // a zero xorshift state would stick at zero
            xs_reg    <= (seed.xs != 32'd0) ? seed.xs : DEF_XOR;
            mwc_reg   <= seed.mwc;
            carry_reg <= 32'(seed.carry);
        end
        else if (step)
        begin
            lcg_reg   <= lcg_next;
            xs_reg    <= xs_next;
            mwc_reg   <= mwc_next;
            carry_reg <= carry_next;
        end
    end

    assign word = lcg_reg + xs_reg + mwc_reg;

endmodule

// ===== hdl/jbrs_front.sv =====
// ------------------------------------------------------------------------
// jbrs_front
// Request intake: classifies each request and queues it for the back end
// ------------------------------------------------------------------------
module jbrs_front
    import jbrs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    input  logic pop,
    output logic head_valid,
    output cmd_t head
);

    cmd_t       q_mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    logic       push;
    cmd_t       cmd;
    logic [15:0] m;

    always_comb
    begin
        m = req.limit - 16'd1;
        m = m | (m >> 1);
        m = m | (m >> 2);
        m = m | (m >> 4);
        m = m | (m >> 8);
        cmd.limit = req.limit;
        cmd.mask  = m;
        unique case (req.action)
            ACT_HALF:   cmd.cls = CLS_HALF;
            ACT_WORD:   cmd.cls = CLS_WORD;
            ACT_BOUND:  cmd.cls = (req.limit < 16'd2) ? CLS_ERROR : CLS_BOUND;
            ACT_RESEED: cmd.cls = CLS_RESEED;
        endcase
    end

    assign req_stall  = (count_reg == 2'd2);
    assign push       = req_valid && !req_stall;
    assign head_valid = (count_reg != 2'd0);
    assign head       = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem_reg[wr_ptr_reg] <= cmd;
    end

endmodule

// ===== hdl/jbrs_back.sv =====
// ------------------------------------------------------------------------
// jbrs_back
// Request execution: refills the halfword buffer, hands out draws, holds the result
// ------------------------------------------------------------------------
module jbrs_back
    import jbrs_pkg::*;
#(
    parameter int BUFFER_WORDS = 512
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  head_valid,
    input  cmd_t                                  head,
    output logic                                  pop,
    input  seed_t                                 seed,
    output logic                                  rsp_valid,
    input  logic                                  rsp_stall,
    output rsp_t                                  rsp,
    output logic [$clog2(2*BUFFER_WORDS+1)-1:0]   pos
);

    localparam int HALVES = 2 * BUFFER_WORDS;
    localparam int PW     = $clog2(HALVES + 1);
    localparam int WAW    = $clog2(BUFFER_WORDS);
    localparam int CW     = $clog2(BUFFER_WORDS + 1);

    state_t state_reg, state_next;

    logic [PW-1:0]  pos_reg;
    logic [CW-1:0]  cnt_reg;
    cmd_t           cur_reg;
    rsp_t           res_reg;
    logic           sel_reg;
    logic           rsp_valid_reg;
    rsp_t           rsp_reg;
    logic [15:0]    even_q, odd_q;

    // low halves at even halfword positions, high halves at odd ones
    logic [15:0] even_mem [BUFFER_WORDS];
    logic [15:0] odd_mem  [BUFFER_WORDS];

    logic [31:0]    gen_word;
    logic           gen_load, gen_step, mem_we, rd_en, rsp_load;
    logic           head_refill, refill_done, data_done, rsp_free;
    logic [PW-1:0]  step_pos;
    logic [WAW-1:0] half_idx, half_idx_up, even_addr, wr_addr;
    logic [CW-1:0]  cnt_m1;
    logic [15:0]    half, draw;
    logic [31:0]    word;

    jbrs_gen u_gen
    (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (gen_load),
        .step  (gen_step),
        .seed  (seed),
        .word  (gen_word)
    );

    always_comb
    begin
        head_refill = (head.cls == CLS_WORD) ? (pos_reg < PW'(2)) : (pos_reg == '0);
        refill_done = (cnt_reg == CW'(BUFFER_WORDS));
        step_pos    = pos_reg - ((cur_reg.cls == CLS_WORD) ? PW'(2) : PW'(1));
        half_idx    = step_pos[WAW:1];
        half_idx_up = half_idx + WAW'(1);
        // misaligned word: high half sits in the next even entry
        even_addr   = (step_pos[0] && cur_reg.cls == CLS_WORD) ? half_idx_up : half_idx;
        cnt_m1      = cnt_reg - CW'(1);
        wr_addr     = cnt_m1[WAW-1:0];
        half        = sel_reg ? odd_q : even_q;
        word        = sel_reg ? {even_q, odd_q} : {odd_q, even_q};
        draw        = half & cur_reg.mask;
        data_done   = (cur_reg.cls != CLS_BOUND) || (draw < cur_reg.limit);
        rsp_free    = !rsp_valid_reg || !rsp_stall;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (head_valid)
                begin
                    if (head.cls == CLS_RESEED || head.cls == CLS_ERROR)
                        state_next = ST_FINISH;
                    else if (head_refill)
                        state_next = ST_REFILL;
                    else
                        state_next = ST_READ;
                end
            end
            ST_REFILL:
            begin
                if (refill_done)
                    state_next = ST_READ;
            end
            ST_READ:
                state_next = ST_DATA;
            ST_DATA:
            begin
                // rejected bounded draw goes round again
                priority if (data_done)
                    state_next = ST_FINISH;
                else if (pos_reg == '0)
                    state_next = ST_REFILL;
                else
                    state_next = ST_READ;
            end
            ST_FINISH:
            begin
                if (rsp_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        pop      = (state_reg == ST_IDLE) && head_valid;
        gen_load = pop && (head.cls == CLS_RESEED);
        gen_step = (state_reg == ST_REFILL) && !refill_done;
        mem_we   = (state_reg == ST_REFILL) && (cnt_reg != '0);
        rd_en    = (state_reg == ST_READ);
        rsp_load = (state_reg == ST_FINISH) && rsp_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (gen_load)
                pos_reg <= '0;
            else if (state_reg == ST_REFILL && refill_done)
                pos_reg <= PW'(HALVES);
            else if (rd_en)
                pos_reg <= step_pos;
            if (state_reg == ST_REFILL)
                cnt_reg <= refill_done ? '0 : cnt_reg + CW'(1);
            rsp_valid_reg <= rsp_load || (rsp_valid_reg && rsp_stall);
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg       <= head;
            res_reg.value <= 32'd0;
            res_reg.error <= (head.cls == CLS_ERROR);
        end
        else if (state_reg == ST_DATA && data_done)
        begin
            res_reg.error <= 1'b0;
            if (cur_reg.cls == CLS_WORD)
                res_reg.value <= word;
            else if (cur_reg.cls == CLS_BOUND)
                res_reg.value <= {16'd0, draw};
            else
                res_reg.value <= {16'd0, half};
        end
        if (rd_en)
            sel_reg <= step_pos[0];
        if (rsp_load)
            rsp_reg <= res_reg;
    end

    // buffer words are written in the cycle after the generator step that makes them
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            even_mem[wr_addr] <= gen_word[15:0];
            odd_mem[wr_addr]  <= gen_word[31:16];
        end
        if (rd_en)
        begin
            even_q <= even_mem[even_addr];
            odd_q  <= odd_mem[half_idx];
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign pos       = pos_reg;

endmodule
